>>> hw/rtl/tlpd_pkg.sv
`timescale 1ns / 1ps

package tlpd_pkg;

    localparam int LENGTH_DIGITS = 9;
    localparam int DIGITS_W      = 4;
    localparam int LEN_W         = 30;
    localparam int BYTE_W        = 8;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;

    localparam logic [DIGITS_W-1:0] DIGITS_INIT = DIGITS_W'(LENGTH_DIGITS);

    localparam logic [BYTE_W-1:0] ENDPOINT_CODE_RESET = 8'd35;
    localparam logic [BYTE_W-1:0] RAW_CODE_RESET      = 8'd36;

    // register index, taken from the word address
    localparam logic REG_ENDPOINT_CODE = 1'b0;
    localparam logic REG_RAW_CODE      = 1'b1;

    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

    localparam logic [1:0] EV_BYTE      = 2'd0;
    localparam logic [1:0] EV_BAD_TYPE  = 2'd1;
    localparam logic [1:0] EV_BAD_DIGIT = 2'd2;
    localparam logic [1:0] EV_EMPTY     = 2'd3;

    localparam logic KIND_ENDPOINT = 1'b0;
    localparam logic KIND_RAW      = 1'b1;

    // one received byte with its classification
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              is_endpoint;
        logic              is_raw;
        logic              is_digit;
        logic [3:0]        digit;
    } byte_class_t;

endpackage

>>> hw/rtl/tlpd_front.sv
`timescale 1ns / 1ps

module tlpd_front
(
    input  logic                                in_valid,
    input  logic [tlpd_pkg::BYTE_W-1:0]         rx_byte,
    input  logic [tlpd_pkg::BYTE_W-1:0]         endpoint_code,
    input  logic [tlpd_pkg::BYTE_W-1:0]         raw_code,
    input  logic                                queue_full,
    output logic                                in_ready,
    output logic                                push,
    output tlpd_pkg::byte_class_t               cls
);

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        cls.data        = rx_byte;
        cls.is_endpoint = (rx_byte == endpoint_code);
        cls.is_raw      = (rx_byte == raw_code);
        cls.is_digit    = (rx_byte >= tlpd_pkg::ASCII_ZERO) && (rx_byte <= tlpd_pkg::ASCII_NINE);
        // low nibble of an ASCII digit is its value
        cls.digit       = rx_byte[3:0];
    end

endmodule

>>> hw/rtl/tlpd_queue.sv
`timescale 1ns / 1ps

module tlpd_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  tlpd_pkg::byte_class_t   push_data,
    input  logic                    pop,
    output logic                    full,
    output logic                    not_empty,
    output tlpd_pkg::byte_class_t   head
);

    tlpd_pkg::byte_class_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hw/rtl/tlpd_back.sv
`timescale 1ns / 1ps

module tlpd_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    input  tlpd_pkg::byte_class_t               item,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tlpd_pkg::BYTE_W-1:0]         out_byte,
    output logic                                msg_kind,
    output logic                                last_of_message,
    output logic [1:0]                          event_code
);

    typedef enum logic [1:0]
    {
        PH_TYPE = 2'd0,
        PH_LEN  = 2'd1,
        PH_PAY  = 2'd2
    } phase_t;

    phase_t                              phase_reg;
    phase_t                              phase_next;
    logic                                kind_reg;
    logic                                kind_next;
    logic [tlpd_pkg::DIGITS_W-1:0]       digits_reg;
    logic [tlpd_pkg::DIGITS_W-1:0]       digits_next;
    logic [tlpd_pkg::LEN_W-1:0]          len_reg;
    logic [tlpd_pkg::LEN_W-1:0]          len_next;

    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [tlpd_pkg::BYTE_W-1:0]         out_byte_reg;
    logic [tlpd_pkg::BYTE_W-1:0]         out_byte_next;
    logic                                out_kind_reg;
    logic                                out_kind_next;
    logic                                out_last_reg;
    logic                                out_last_next;
    logic [1:0]                          out_event_reg;
    logic [1:0]                          out_event_next;

    logic [tlpd_pkg::LEN_W-1:0]          len_acc;
    logic [tlpd_pkg::LEN_W-1:0]          len_dec;
    logic [tlpd_pkg::DIGITS_W-1:0]       digits_dec;

    // a new item may enter whenever the output slot is free or being emptied
    assign pop = item_valid && (!out_valid_reg || out_ready);

    assign out_valid       = out_valid_reg;
    assign out_byte        = out_byte_reg;
    assign msg_kind        = out_kind_reg;
    assign last_of_message = out_last_reg;
    assign event_code      = out_event_reg;

    // len * 10 + digit, wrapping at the length width
    assign len_acc = {len_reg[tlpd_pkg::LEN_W-4:0], 3'b000}
                   + {len_reg[tlpd_pkg::LEN_W-2:0], 1'b0}
                   + tlpd_pkg::LEN_W'(item.digit);
    assign len_dec    = len_reg - tlpd_pkg::LEN_W'(1);
    assign digits_dec = (digits_reg != '0) ? digits_reg - tlpd_pkg::DIGITS_W'(1) : digits_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        digits_next    = digits_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        out_event_next = out_event_reg;

        if (pop)
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    if (!item.is_digit)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = '0;
                        out_kind_next  = kind_reg;
                        out_last_next  = 1'b0;
                        out_event_next = tlpd_pkg::EV_BAD_DIGIT;
                        phase_next     = PH_TYPE;
                        digits_next    = tlpd_pkg::DIGITS_INIT;
                        len_next       = '0;
                    end
                    else if (digits_dec != '0)
                    begin
                        digits_next = digits_dec;
                        len_next    = len_acc;
                    end
                    else if (len_acc == '0)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = '0;
                        out_kind_next  = kind_reg;
                        out_last_next  = 1'b1;
                        out_event_next = tlpd_pkg::EV_EMPTY;
                        phase_next     = PH_TYPE;
                        digits_next    = tlpd_pkg::DIGITS_INIT;
                        len_next       = '0;
                    end
                    else
                    begin
                        phase_next  = PH_PAY;
                        digits_next = digits_dec;
                        len_next    = len_acc;
                    end
                end
                PH_PAY:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = item.data;
                    out_kind_next  = kind_reg;
                    out_last_next  = (len_dec == '0);
                    out_event_next = tlpd_pkg::EV_BYTE;
                    if (len_dec == '0)
                    begin
                        phase_next  = PH_TYPE;
                        digits_next = tlpd_pkg::DIGITS_INIT;
                        len_next    = '0;
                    end
                    else
                    begin
                        len_next = len_dec;
                    end
                end
                default:
                begin
                    phase_next  = PH_TYPE;
                    digits_next = tlpd_pkg::DIGITS_INIT;
                    len_next    = '0;
                    if (item.is_endpoint)
                    begin
                        kind_next  = tlpd_pkg::KIND_ENDPOINT;
                        phase_next = PH_LEN;
                    end
                    else if (item.is_raw)
                    begin
                        kind_next  = tlpd_pkg::KIND_RAW;
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = '0;
                        out_kind_next  = tlpd_pkg::KIND_ENDPOINT;
                        out_last_next  = 1'b0;
                        out_event_next = tlpd_pkg::EV_BAD_TYPE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TYPE;
            kind_reg      <= tlpd_pkg::KIND_ENDPOINT;
            digits_reg    <= tlpd_pkg::DIGITS_INIT;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_kind_reg  <= 1'b0;
            out_last_reg  <= 1'b0;
            out_event_reg <= tlpd_pkg::EV_BYTE;
        end
        else
        begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            digits_reg    <= digits_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_kind_reg  <= out_kind_next;
            out_last_reg  <= out_last_next;
            out_event_reg <= out_event_next;
        end
    end

endmodule

>>> hw/rtl/type_length_payload_deframer_top.sv
`timescale 1ns / 1ps

// Deframer for a serial byte stream of type/length/payload frames: one type byte
// (endpoint or raw code, both set through the register port), nine ASCII decimal
// length digits, then the payload. Takes one byte per cycle while the queue is not
// full and the output not stalled, the back end doing its state update (length
// multiply-add and compare) as it pops each byte; each result is held in the output
// register. Each payload byte comes out with its message kind and a last flag; a bad
// type byte or a non-digit in the length gives an error result, and a zero length
// gives one empty-message result. A two-entry queue between the classifier and the
// parser, plus the output register, lets input and output stall independently.
module type_length_payload_deframer_top
(
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [tlpd_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [tlpd_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [tlpd_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready,

    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [tlpd_pkg::BYTE_W-1:0]             rx_byte,

    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [tlpd_pkg::BYTE_W-1:0]             out_byte,
    output logic                                    msg_kind,
    output logic                                    last_of_message,
    output logic [1:0]                              event_code
);

    logic [tlpd_pkg::BYTE_W-1:0] endpoint_code_reg;
    logic [tlpd_pkg::BYTE_W-1:0] raw_code_reg;
    logic                        reg_sel;
    logic                        cfg_write;

    logic                        queue_full;
    logic                        queue_not_empty;
    logic                        push;
    logic                        pop;
    tlpd_pkg::byte_class_t       push_cls;
    tlpd_pkg::byte_class_t       head_cls;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            endpoint_code_reg <= tlpd_pkg::ENDPOINT_CODE_RESET;
            raw_code_reg      <= tlpd_pkg::RAW_CODE_RESET;
        end
        else if (cfg_write)
        begin
            if (reg_sel == tlpd_pkg::REG_ENDPOINT_CODE)
            begin
                endpoint_code_reg <= pwdata[tlpd_pkg::BYTE_W-1:0];
            end
            else
            begin
                raw_code_reg <= pwdata[tlpd_pkg::BYTE_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (reg_sel == tlpd_pkg::REG_ENDPOINT_CODE)
        begin
            prdata = tlpd_pkg::APB_DATA_W'(endpoint_code_reg);
        end
        else
        begin
            prdata = tlpd_pkg::APB_DATA_W'(raw_code_reg);
        end
    end

    tlpd_front u_front
    (
        .in_valid      (in_valid),
        .rx_byte       (rx_byte),
        .endpoint_code (endpoint_code_reg),
        .raw_code      (raw_code_reg),
        .queue_full    (queue_full),
        .in_ready      (in_ready),
        .push          (push),
        .cls           (push_cls)
    );

    tlpd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cls),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head_cls)
    );

    tlpd_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (queue_not_empty),
        .item            (head_cls),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .msg_kind        (msg_kind),
        .last_of_message (last_of_message),
        .event_code      (event_code)
    );

`ifndef SYNTHESIS
    a_zero_byte_on_events : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_code != tlpd_pkg::EV_BYTE) |-> (out_byte == '0))
        else $error("non-payload result carries a nonzero byte");

    a_errors_not_last : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((event_code == tlpd_pkg::EV_BAD_TYPE) ||
                      (event_code == tlpd_pkg::EV_BAD_DIGIT)) |-> !last_of_message)
        else $error("error result flagged as last of message");

    a_empty_is_last : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_code == tlpd_pkg::EV_EMPTY) |-> last_of_message)
        else $error("empty-message result not flagged as last");

    a_bad_type_kind : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_code == tlpd_pkg::EV_BAD_TYPE) |-> !msg_kind)
        else $error("bad type result carries raw kind");
`endif

endmodule

>>> dv/type_length_payload_deframer_top_tb.sv
`timescale 1ns / 1ps

module type_length_payload_deframer_top_tb;

    typedef enum logic [1:0] { PH_TYPE, PH_LENGTH, PH_PAYLOAD } parse_phase_t;

    typedef struct packed {
        logic [tlpd_pkg::BYTE_W-1:0] data;
        logic                        kind;
        logic                        last;
        logic [1:0]                  ev;
    } frame_result_t;

    localparam int ITEM_TARGET = 1250;
    localparam int DRAIN_PAUSE = 8;
    localparam int RING_DEPTH  = 64;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [tlpd_pkg::APB_ADDR_W-1:0] paddr;
    logic [tlpd_pkg::APB_DATA_W-1:0] pwdata;
    logic [tlpd_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            in_valid;
    logic                            in_ready;
    logic [tlpd_pkg::BYTE_W-1:0]     rx_byte;
    logic                            out_valid;
    logic                            out_ready;
    logic [tlpd_pkg::BYTE_W-1:0]     out_byte;
    logic                            msg_kind;
    logic                            last_of_message;
    logic [1:0]                      event_code;

    // parser copy kept in step with every accepted byte
    logic [tlpd_pkg::BYTE_W-1:0]     endpoint_code;
    logic [tlpd_pkg::BYTE_W-1:0]     raw_code;
    parse_phase_t                    parse_phase;
    logic                            kind_held;
    logic [tlpd_pkg::DIGITS_W-1:0]   digits_left;
    logic [tlpd_pkg::LEN_W-1:0]      length_left;

    // predicted results in order; entries between pend_rd and pend_wr are outstanding
    frame_result_t                   pending_result [RING_DEPTH];
    int                              pend_wr;
    int                              pend_rd;

    int send_idle_pct;
    int recv_stall_pct;
    int bytes_sent;
    int results_seen;
    int reg_writes;
    int mismatches;

    type_length_payload_deframer_top i_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .msg_kind        (msg_kind),
        .last_of_message (last_of_message),
        .event_code      (event_code)
    );

    initial clk = 1'b0;

    always #5 clk = ~clk;

    function automatic void restart_parse();
        parse_phase = PH_TYPE;
        digits_left = tlpd_pkg::DIGITS_INIT;
        length_left = '0;
    endfunction

    // advance the parser copy by one byte; returns 1 when the byte yields a result
    function automatic bit deframe_predict(input logic [tlpd_pkg::BYTE_W-1:0] b,
                                           output frame_result_t r);
        bit hit;
        hit    = 1'b0;
        r.data = '0;
        r.kind = tlpd_pkg::KIND_ENDPOINT;
        r.last = 1'b0;
        r.ev   = tlpd_pkg::EV_BYTE;
        case (parse_phase)
            PH_LENGTH:
            begin
                if (b < tlpd_pkg::ASCII_ZERO || b > tlpd_pkg::ASCII_NINE)
                begin
                    r.kind = kind_held;
                    r.ev   = tlpd_pkg::EV_BAD_DIGIT;
                    hit    = 1'b1;
                    restart_parse();
                end
                else
                begin
                    length_left = tlpd_pkg::LEN_W'(length_left * 10 +
                                                   (b - tlpd_pkg::ASCII_ZERO));
                    if (digits_left != 0)
                        digits_left = digits_left - 1'b1;
                    if (digits_left == 0)
                    begin
                        if (length_left == 0)
                        begin
                            r.kind = kind_held;
                            r.last = 1'b1;
                            r.ev   = tlpd_pkg::EV_EMPTY;
                            hit    = 1'b1;
                            restart_parse();
                        end
                        else
                            parse_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                length_left = length_left - 1'b1;
                r.data      = b;
                r.kind      = kind_held;
                r.last      = (length_left == 0);
                hit         = 1'b1;
                if (r.last)
                    restart_parse();
            end
            default:
            begin
                restart_parse();
                // endpoint wins when both codes are equal
                if (b == endpoint_code)
                begin
                    kind_held   = tlpd_pkg::KIND_ENDPOINT;
                    parse_phase = PH_LENGTH;
                end
                else if (b == raw_code)
                begin
                    kind_held   = tlpd_pkg::KIND_RAW;
                    parse_phase = PH_LENGTH;
                end
                else
                begin
                    r.ev = tlpd_pkg::EV_BAD_TYPE;
                    hit  = 1'b1;
                end
            end
        endcase
        return hit;
    endfunction

    function automatic logic [tlpd_pkg::BYTE_W-1:0] random_non_digit();
        logic [tlpd_pkg::BYTE_W-1:0] b;
        do
            b = tlpd_pkg::BYTE_W'($urandom_range(255));
        while (b >= tlpd_pkg::ASCII_ZERO && b <= tlpd_pkg::ASCII_NINE);
        return b;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [tlpd_pkg::BYTE_W-1:0] want,
                                        input logic [tlpd_pkg::BYTE_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    task automatic send_byte(input logic [tlpd_pkg::BYTE_W-1:0] b);
        frame_result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        if (deframe_predict(b, r))
        begin
            if (pend_wr - pend_rd >= RING_DEPTH)
            begin
                mismatches++;
                $display("%0t: too many results outstanding, expected at most %0d, actual %0d",
                         $time, RING_DEPTH - 1, pend_wr - pend_rd);
            end
            pending_result[pend_wr % RING_DEPTH] = r;
            pend_wr++;
        end
        bytes_sent++;
    endtask

    // type byte and length digits; a non-digit replaces the digit at bad_pos
    task automatic send_header(input logic [tlpd_pkg::BYTE_W-1:0] type_code, input int len,
                               input int bad_pos = -1,
                               input logic [tlpd_pkg::BYTE_W-1:0] bad_char =
                                   tlpd_pkg::ASCII_ZERO - 8'd1);
        int scale;
        scale = 1;
        repeat (tlpd_pkg::LENGTH_DIGITS - 1)
            scale = scale * 10;
        send_byte(type_code);
        for (int i = 0; i < tlpd_pkg::LENGTH_DIGITS; i++)
        begin
            if (i == bad_pos)
            begin
                send_byte(bad_char);
                return;
            end
            send_byte(tlpd_pkg::ASCII_ZERO + tlpd_pkg::BYTE_W'((len / scale) % 10));
            scale = scale / 10;
        end
    endtask

    task automatic send_frame(input logic [tlpd_pkg::BYTE_W-1:0] type_code, input int len);
        send_header(type_code, len);
        repeat (len)
            send_byte(tlpd_pkg::BYTE_W'($urandom_range(255)));
    endtask

    task automatic send_random_frame();
        int                          pick;
        int                          len;
        logic [tlpd_pkg::BYTE_W-1:0] code;
        code = $urandom_range(1) ? raw_code : endpoint_code;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            send_byte(tlpd_pkg::BYTE_W'($urandom_range(255)));
            // a stray byte may open a frame; break it before the next one
            while (parse_phase == PH_LENGTH)
                send_byte(random_non_digit());
        end
        else if (pick < 16)
            send_header(code, $urandom_range(999999999),
                        $urandom_range(tlpd_pkg::LENGTH_DIGITS - 1), random_non_digit());
        else
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                len = 0;
            else if (pick < 85)
                len = $urandom_range(12, 1);
            else if (pick < 98)
                len = $urandom_range(80, 13);
            else
                len = $urandom_range(400, 81);
            send_frame(code, len);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pend_wr != pend_rd)
            @(posedge clk);
        // bytes that give no result may still be in flight
        repeat (DRAIN_PAUSE)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [tlpd_pkg::BYTE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= tlpd_pkg::APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == tlpd_pkg::REG_ENDPOINT_CODE)
            endpoint_code = value;
        else
            raw_code = value;
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic set_codes(input logic [tlpd_pkg::BYTE_W-1:0] ep,
                             input logic [tlpd_pkg::BYTE_W-1:0] raw);
        drain_results();
        write_reg(tlpd_pkg::REG_ENDPOINT_CODE, ep);
        write_reg(tlpd_pkg::REG_RAW_CODE, raw);
    endtask

    task automatic test_reset_codes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_header(tlpd_pkg::ENDPOINT_CODE_RESET, 2);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_header(tlpd_pkg::RAW_CODE_RESET, 0);
        send_header(tlpd_pkg::RAW_CODE_RESET, 0, 0, tlpd_pkg::ASCII_NINE + 8'd1);
        send_header(tlpd_pkg::ENDPOINT_CODE_RESET, 9, tlpd_pkg::LENGTH_DIGITS - 1,
                    tlpd_pkg::ASCII_ZERO - 8'd1);
        drain_results();
    endtask

    task automatic test_code_extremes();
        set_codes(8'h00, 8'hFF);
        send_frame(8'h00, 1);
        send_frame(8'hFF, 2);
        send_byte(8'h80);
        set_codes(8'hFF, 8'h00);
        send_frame(8'h00, 1);
        send_frame(8'hFF, 0);
        // equal codes: frame must come out as endpoint
        set_codes(8'h41, 8'h41);
        send_frame(8'h41, 3);
        send_header(8'h41, 0);
        send_byte(8'h42);
        repeat (6)
            send_random_frame();
        drain_results();
    endtask

    task automatic test_random_traffic();
        int idle_mix[4]  = '{0, 86, 0, 27};
        int stall_mix[4] = '{0, 0, 86, 27};
        int phase_end;
        for (int p = 0; p < 4; p++)
        begin
            set_codes(tlpd_pkg::BYTE_W'($urandom_range(255)),
                      tlpd_pkg::BYTE_W'($urandom_range(255)));
            send_idle_pct  = idle_mix[p];
            recv_stall_pct = stall_mix[p];
            // split what is left of the byte budget over the remaining mixes
            phase_end      = bytes_sent + (ITEM_TARGET - bytes_sent) / (4 - p);
            while (bytes_sent < phase_end)
                send_random_frame();
            drain_results();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    always @(posedge clk)
    begin : result_check
        frame_result_t want;
        if (rst_n)
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pend_wr == pend_rd)
                begin
                    mismatches++;
                    $display("%0t: result with none expected: byte %0h kind %0b last %0b event %0d",
                             $time, out_byte, msg_kind, last_of_message, event_code);
                end
                else
                begin
                    want = pending_result[pend_rd % RING_DEPTH];
                    pend_rd++;
                    check_field("out_byte", want.data, out_byte);
                    check_field("msg_kind", tlpd_pkg::BYTE_W'(want.kind),
                                tlpd_pkg::BYTE_W'(msg_kind));
                    check_field("last_of_message", tlpd_pkg::BYTE_W'(want.last),
                                tlpd_pkg::BYTE_W'(last_of_message));
                    check_field("event_code", tlpd_pkg::BYTE_W'(want.ev),
                                tlpd_pkg::BYTE_W'(event_code));
                end
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        rx_byte        = '0;
        out_ready      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        bytes_sent     = 0;
        results_seen   = 0;
        reg_writes     = 0;
        mismatches     = 0;
        pend_wr        = 0;
        pend_rd        = 0;
        endpoint_code  = tlpd_pkg::ENDPOINT_CODE_RESET;
        raw_code       = tlpd_pkg::RAW_CODE_RESET;
        kind_held      = tlpd_pkg::KIND_ENDPOINT;
        restart_parse();
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_codes();
        test_code_extremes();
        test_random_traffic();
        drain_results();

        $display("Sent %0d bytes through the deframer, checked %0d results", bytes_sent,
                 results_seen);
        $display("Made %0d type code writes under four sender/receiver stall mixes", reg_writes);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Timed out with %0d results outstanding", pend_wr - pend_rd);
        $display("Mismatches found");
        $finish;
    end

endmodule
